[rtl/core/lcp_pkg.sv]
// Package for the lattice contact process core: field widths, codes and request/result types.
package lcp_pkg;

    localparam int SIDE_DEFAULT = 128;
    localparam int ROW_W        = 7;
    localparam int DIR_W        = 3;
    localparam int DRAW_W       = 16;
    localparam int COUNT_W      = 15;
    localparam int THRESH_W     = 16;

    // round(0.7265 * 65536)
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd47612;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    // Moore neighbor directions
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP         = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd6;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NBR,
        ST_EXEC
    } lcp_state_t;

    typedef struct packed {
        logic              req_type;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DIR_W-1:0]  direction;
        logic [DRAW_W-1:0] draw;
        logic              load_state;
    } lcp_req_t;

    typedef struct packed {
        logic               changed;
        logic [ROW_W-1:0]   changed_row;
        logic [ROW_W-1:0]   changed_col;
        logic               new_cell_state;
        logic [COUNT_W-1:0] infected_count;
    } lcp_result_t;

endpackage

[rtl/core/lattice_contact_process_step_core.sv]
// Top level of the lattice contact process core: lattice memory, sequencer and result register.
// Each request goes through the neighbor-read and execute states; its strobe is registered
//   from execute. The memory port does one read per cycle, active cell then neighbor; the write
//   lands in execute, the cycle in which the next request can be taken.
// Reset: clears the count and restores the threshold, then sweeps the lattice to susceptible,
//   one cell per cycle, all (2**clog2(SIDE))**2 cells (16384 at SIDE 128), with busy high.
// Results go out for one cycle each; the receiver cannot stall them.
module lattice_contact_process_step_core #(
    parameter int SIDE = lcp_pkg::SIDE_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lcp_pkg::lcp_req_t            req,
    output logic                         result_valid,
    output lcp_pkg::lcp_result_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lcp_pkg::THRESH_W-1:0] cfg_data
);
    import lcp_pkg::*;

    // coordinate width and lattice address (row in the high half, column in the low half)
    localparam int CW        = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW        = 2 * CW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int ROW_SPAN  = 1 << ROW_W;
    localparam int XW        = (CW > ROW_W) ? CW : ROW_W;
    localparam logic [CW-1:0] COORD_MAX = CW'(SIDE - 1);

    // modulo-SIDE reduction of a 7-bit coordinate, built by counting at elaboration
    typedef logic [CW-1:0] red_tab_t [ROW_SPAN];

    function automatic red_tab_t build_red_tab();
        red_tab_t    tab;
        int unsigned m;
        m = 0;
        for (int i = 0; i < ROW_SPAN; i++)
        begin
            tab[i] = CW'(m);
            if (m == SIDE - 1)
                m = 0;
            else
                m = m + 1;
        end
        return tab;
    endfunction

    localparam red_tab_t RED_TAB = build_red_tab();

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    lcp_state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // captured request
    logic                kind_reg;
    logic [DRAW_W-1:0]   draw_reg;
    logic                ld_reg;
    logic [CW-1:0]       act_row_reg, act_col_reg;
    logic [CW-1:0]       nbr_row_reg, nbr_col_reg;
    logic                act_state_reg;

    // result register
    logic                result_valid_reg;
    lcp_result_t         result_reg;

    // lattice memory, one write port and one registered read port
    logic                mem_array [MEM_DEPTH];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic                mem_rdata;

    logic accept;
    logic clear_done;

    // request decode in the accept cycle
    logic [CW-1:0] in_row, in_col;
    logic [CW-1:0] row_dec, row_inc, col_dec, col_inc;
    logic [CW-1:0] in_nbr_row, in_nbr_col;

    // execute decision
    logic               chg;
    logic [CW-1:0]      chg_row, chg_col;
    logic               chg_val;
    logic [COUNT_W-1:0] count_next;
    logic [XW-1:0]      chg_row_x, chg_col_x;

    assign accept     = start && !busy;
    assign clear_done = (clr_reg == {AW{1'b1}});
    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------
    // coordinates and torus neighbor
    // ---------------------------------------------------------------
    always_comb
    begin
        in_row  = RED_TAB[req.row];
        in_col  = RED_TAB[req.col];
        row_dec = (in_row == '0) ? COORD_MAX : in_row - 1'b1;
        row_inc = (in_row == COORD_MAX) ? '0 : in_row + 1'b1;
        col_dec = (in_col == '0) ? COORD_MAX : in_col - 1'b1;
        col_inc = (in_col == COORD_MAX) ? '0 : in_col + 1'b1;

        case (req.direction) inside
            DIR_UP_RIGHT, DIR_UP, DIR_UP_LEFT:       in_nbr_row = row_dec;
            DIR_DOWN_LEFT, DIR_DOWN, DIR_DOWN_RIGHT: in_nbr_row = row_inc;
            default:                                 in_nbr_row = in_row;
        endcase

        case (req.direction) inside
            DIR_UP_LEFT, DIR_LEFT, DIR_DOWN_LEFT:    in_nbr_col = col_dec;
            DIR_UP_RIGHT, DIR_DOWN_RIGHT, DIR_RIGHT: in_nbr_col = col_inc;
            default:                                 in_nbr_col = in_col;
        endcase
    end

    // ---------------------------------------------------------------
    // execute: decide the one cell that may change
    // act_state_reg holds the active cell, mem_rdata the neighbor
    // ---------------------------------------------------------------
    always_comb
    begin
        chg     = 1'b0;
        chg_row = act_row_reg;
        chg_col = act_col_reg;
        chg_val = 1'b0;
        if (kind_reg == REQ_LOAD)
        begin
            chg     = (act_state_reg != ld_reg);
            chg_val = ld_reg;
        end
        else if (draw_reg < thresh_reg)
        begin
            // infected active cell infects a susceptible neighbor
            chg     = act_state_reg && !mem_rdata;
            chg_row = nbr_row_reg;
            chg_col = nbr_col_reg;
            chg_val = 1'b1;
        end
        else
        begin
            // recovery of the active cell
            chg     = act_state_reg;
            chg_val = 1'b0;
        end

        if (!chg)
            count_next = count_reg;
        else if (chg_val)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg - 1'b1;

        chg_row_x = XW'(chg_row);
        chg_col_x = XW'(chg_col);
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_NBR;
            ST_NBR:   state_next = ST_EXEC;
            ST_EXEC:  state_next = start ? ST_NBR : ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: outputs and memory port control
    // A new request is taken in the execute cycle; its active-cell read
    // then meets the write of the previous one, which the memory forwards.
    // ---------------------------------------------------------------
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = {chg_row, chg_col};
        mem_wdata = chg_val;
        mem_raddr = {in_row, in_col};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_NBR:
            begin
                mem_raddr = {nbr_row_reg, nbr_col_reg};
            end
            ST_EXEC:
            begin
                busy   = 1'b0;
                mem_we = chg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // lattice memory
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_array[mem_waddr] <= mem_wdata;
        if (mem_we && (mem_waddr == mem_raddr))
            mem_rdata <= mem_wdata;
        else
            mem_rdata <= mem_array[mem_raddr];
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            count_reg        <= '0;
            thresh_reg       <= THRESH_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_EXEC);
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_EXEC)
                count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                thresh_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // request and result payload
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.req_type;
            draw_reg    <= req.draw;
            ld_reg      <= req.load_state;
            act_row_reg <= in_row;
            act_col_reg <= in_col;
            nbr_row_reg <= in_nbr_row;
            nbr_col_reg <= in_nbr_col;
        end
        if (state_reg == ST_NBR)
            act_state_reg <= mem_rdata;
        if (state_reg == ST_EXEC)
        begin
            result_reg.changed        <= chg;
            result_reg.changed_row    <= chg ? chg_row_x[ROW_W-1:0] : '0;
            result_reg.changed_col    <= chg ? chg_col_x[ROW_W-1:0] : '0;
            result_reg.new_cell_state <= chg && chg_val;
            result_reg.infected_count <= count_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // every accepted request gives its strobe after the neighbor-read and execute states
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 result_valid)
        else $error("result strobe missing after accepted request");

    // an accepted request is followed by busy, so requests are never taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted in back-to-back cycles");

    // the count moves only with a reported change
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.changed) |-> (result.infected_count == count_reg))
        else $error("infected count moved without a change");
`endif

endmodule
